// ===== rtl/atrsp_pkg.sv =====
// Shared constants, literal text and types of the response stream parser.
package atrsp_pkg;

    localparam int LINE_BUFFER_BYTES = 128;
    localparam int CHUNK_BYTES       = 128;

    localparam int LINE_W  = $clog2(LINE_BUFFER_BYTES);
    localparam int CHUNK_W = $clog2(CHUNK_BYTES + 1);
    localparam int LEN_W   = 31;
    localparam logic [LEN_W-1:0] LEN_LIMIT = {LEN_W{1'b1}};

    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] EV_PAYLOAD   = 3'd0;
    localparam logic [KIND_W-1:0] EV_OK        = 3'd1;
    localparam logic [KIND_W-1:0] EV_ERROR     = 3'd2;
    localparam logic [KIND_W-1:0] EV_SEND_OK   = 3'd3;
    localparam logic [KIND_W-1:0] EV_GOT_IP    = 3'd4;
    localparam logic [KIND_W-1:0] EV_LINK_DOWN = 3'd5;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Literals compared from the start of the line
    localparam int NUM_LIT = 7;
    localparam int L_IPD       = 0;
    localparam int L_OK        = 1;
    localparam int L_ERROR     = 2;
    localparam int L_FAIL      = 3;
    localparam int L_SEND_OK   = 4;
    localparam int L_SEND_FAIL = 5;
    localparam int L_CLOSED    = 6;

    // Literals searched anywhere in the line
    localparam int NUM_SUB = 2;
    localparam int S_GOT_IP = 0;
    localparam int S_DISC   = 1;

    localparam int WIN_BYTES = 15;
    localparam int LIT_BITS  = 8 * WIN_BYTES;

    // Text right-aligned: byte i of a literal of length n sits at 8*(n-1-i)
    localparam logic [LIT_BITS-1:0] LIT_TEXT [NUM_LIT] = '{
        LIT_BITS'("+IPD,"), LIT_BITS'("OK"), LIT_BITS'("ERROR"), LIT_BITS'("FAIL"),
        LIT_BITS'("SEND OK"), LIT_BITS'("SEND FAIL"), LIT_BITS'("CLOSED")
    };
    localparam int LIT_LEN [NUM_LIT] = '{5, 2, 5, 4, 7, 9, 6};

    localparam logic [LIT_BITS-1:0] SUB_TEXT [NUM_SUB] = '{
        LIT_BITS'("WIFI GOT IP"), LIT_BITS'("WIFI DISCONNECT")
    };
    localparam int SUB_LEN [NUM_SUB] = '{11, 15};

    typedef struct packed {
        logic               valid;
        logic [KIND_W-1:0]  kind;
        logic [7:0]         data;
        logic               chunk_last;
        logic               payload_last;
    } evt_t;

    typedef struct packed {
        logic             clear;
        logic             step;
    } num_ctl_t;

endpackage

// ===== rtl/atrsp_num.sv =====
// Incremental decimal reader for the payload length of a header line.
module atrsp_num
    import atrsp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  num_ctl_t         ctl,
    input  logic [7:0]       rx_byte,
    output logic [LEN_W-1:0] value,
    output logic             negative
);

    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] value_reg, value_next;
    logic             neg_reg, neg_next;
    logic             is_digit, is_space;
    logic [LEN_W+3:0] wide, prod;
    logic [3:0]       digit;

    always_comb begin
        is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
        is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
        digit    = 4'(rx_byte - CH_ZERO);
        wide     = (LEN_W+4)'(value_reg);
        prod     = (wide << 3) + (wide << 1) + (LEN_W+4)'(digit);

        phase_next = phase_reg;
        value_next = value_reg;
        neg_next   = neg_reg;
        if (ctl.clear) begin
            phase_next = PH_SPACE;
            value_next = '0;
            neg_next   = 1'b0;
        end else if (ctl.step) begin
            unique case (phase_reg)
                PH_SPACE: begin
                    if (is_digit) begin
                        phase_next = PH_DIGIT;
                        value_next = LEN_W'(digit);
                    end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
                        phase_next = PH_SIGN;
                        neg_next   = (rx_byte == CH_MINUS);
                    end else if (!is_space) begin
                        phase_next = PH_DONE;
                    end
                end
                PH_SIGN, PH_DIGIT: begin
                    if (is_digit) begin
                        phase_next = PH_DIGIT;
                        value_next = (prod > (LEN_W+4)'(LEN_LIMIT)) ? LEN_LIMIT
                                                                    : prod[LEN_W-1:0];
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SPACE;
            value_reg <= '0;
            neg_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            value_reg <= value_next;
            neg_reg   <= neg_next;
        end
    end

    assign value    = value_reg;
    assign negative = neg_reg;

endmodule

// ===== rtl/atrsp_core.sv =====
// Per-byte parser state: line matching, payload counting and event decision.
module atrsp_core
    import atrsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output evt_t       evt
);

    logic               pay_mode_reg, pay_mode_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next, chunk_inc;
    logic [LINE_W-1:0]  len_reg, len_next, len_eff;
    logic [LINE_W:0]    len_new;
    logic [NUM_LIT-1:0] lit_ok_reg, lit_ok_next;
    logic [NUM_SUB-1:0] found_reg, found_next;
    logic               zero_seen_reg, zero_seen_next;
    logic [LINE_W-1:0]  zero_pos_reg, zero_pos_next;
    logic               last_cr_reg, last_cr_next;
    logic [7:0]         win_reg [WIN_BYTES-1];
    logic [7:0]         cand [WIN_BYTES];
    logic               shift_win, last, chunk_end, sub_hit;
    logic [NUM_LIT-1:0] exact;
    logic [LEN_W-1:0]   num_value;
    logic               num_neg;
    num_ctl_t           num_ctl;

    atrsp_num u_num (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (num_ctl),
        .rx_byte  (rx_byte),
        .value    (num_value),
        .negative (num_neg)
    );

    always_comb begin
        cand[WIN_BYTES-1] = rx_byte;
        for (int j = 0; j < WIN_BYTES - 1; j++) begin
            cand[j] = win_reg[WIN_BYTES-2-j];
        end
    end

    always_comb begin
        pay_mode_next  = pay_mode_reg;
        remain_next    = remain_reg;
        chunk_next     = chunk_reg;
        len_next       = len_reg;
        lit_ok_next    = lit_ok_reg;
        found_next     = found_reg;
        zero_seen_next = zero_seen_reg;
        zero_pos_next  = zero_pos_reg;
        last_cr_next   = last_cr_reg;
        shift_win      = 1'b0;
        sub_hit        = 1'b0;
        num_ctl        = '0;
        evt            = '0;
        len_new        = {1'b0, len_reg} + 1'b1;
        chunk_inc      = chunk_reg + 1'b1;
        last           = (remain_reg == LEN_W'(1));
        chunk_end      = last || (chunk_inc >= CHUNK_W'(CHUNK_BYTES));
        len_eff        = zero_seen_reg ? zero_pos_reg
                       : (last_cr_reg ? len_reg - 1'b1 : len_reg);
        for (int l = 0; l < NUM_LIT; l++) begin
            exact[l] = lit_ok_reg[l] && (len_eff == LINE_W'(LIT_LEN[l]));
        end

        if (step) begin
            if (pay_mode_reg) begin
                remain_next      = remain_reg - 1'b1;
                chunk_next       = chunk_end ? '0 : chunk_inc;
                pay_mode_next    = !last;
                evt.valid        = 1'b1;
                evt.kind         = EV_PAYLOAD;
                evt.data         = rx_byte;
                evt.chunk_last   = chunk_end;
                evt.payload_last = last;
            end else if (rx_byte == CH_LF) begin
                evt.valid = (len_eff != '0);
                priority if (exact[L_OK]) evt.kind = EV_OK;
                else if (exact[L_ERROR] || exact[L_FAIL]) evt.kind = EV_ERROR;
                else if (exact[L_SEND_OK]) evt.kind = EV_SEND_OK;
                else if (exact[L_SEND_FAIL]) evt.kind = EV_ERROR;
                else if (found_reg[S_GOT_IP]) evt.kind = EV_GOT_IP;
                else if (found_reg[S_DISC]) evt.kind = EV_LINK_DOWN;
                else if (exact[L_CLOSED]) evt.kind = EV_LINK_DOWN;
                else evt.valid = 1'b0;
                len_next = '0;
            end else if (len_reg >= LINE_W'(LINE_BUFFER_BYTES - 1)) begin
                // drop the byte and the overlong line
                len_next = '0;
            end else begin
                len_next     = len_new[LINE_W-1:0];
                shift_win    = 1'b1;
                last_cr_next = (rx_byte == CH_CR);
                if (!zero_seen_reg && rx_byte == 8'h00) begin
                    zero_seen_next = 1'b1;
                    zero_pos_next  = len_reg;
                end
                for (int l = 0; l < NUM_LIT; l++) begin
                    for (int i = 0; i < LIT_LEN[l]; i++) begin
                        if (len_reg == LINE_W'(i)
                            && rx_byte != LIT_TEXT[l][8*(LIT_LEN[l]-1-i) +: 8]) begin
                            lit_ok_next[l] = 1'b0;
                        end
                    end
                end
                for (int s = 0; s < NUM_SUB; s++) begin
                    sub_hit = 1'b1;
                    for (int i = 0; i < SUB_LEN[s]; i++) begin
                        if (cand[WIN_BYTES-SUB_LEN[s]+i]
                            != SUB_TEXT[s][8*(SUB_LEN[s]-1-i) +: 8]) begin
                            sub_hit = 1'b0;
                        end
                    end
                    if (sub_hit && !zero_seen_reg && len_new >= (LINE_W+1)'(SUB_LEN[s])) begin
                        found_next[s] = 1'b1;
                    end
                end
                num_ctl.step = (len_reg >= LINE_W'(5));
                if (rx_byte == CH_COLON && len_reg >= LINE_W'(5) && lit_ok_reg[L_IPD]) begin
                    remain_next   = num_value;
                    chunk_next    = '0;
                    pay_mode_next = (num_value != '0) && !num_neg;
                    len_next      = '0;
                end
            end
            // empty line: restart all per-line matching
            if (len_next == '0) begin
                lit_ok_next    = '1;
                found_next     = '0;
                zero_seen_next = 1'b0;
                last_cr_next   = 1'b0;
                num_ctl.clear  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pay_mode_reg  <= 1'b0;
            remain_reg    <= '0;
            chunk_reg     <= '0;
            len_reg       <= '0;
            lit_ok_reg    <= '1;
            found_reg     <= '0;
            zero_seen_reg <= 1'b0;
            zero_pos_reg  <= '0;
            last_cr_reg   <= 1'b0;
        end else begin
            pay_mode_reg  <= pay_mode_next;
            remain_reg    <= remain_next;
            chunk_reg     <= chunk_next;
            len_reg       <= len_next;
            lit_ok_reg    <= lit_ok_next;
            found_reg     <= found_next;
            zero_seen_reg <= zero_seen_next;
            zero_pos_reg  <= zero_pos_next;
            last_cr_reg   <= last_cr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < WIN_BYTES - 1; j++) win_reg[j] <= '0;
        end else if (shift_win) begin
            win_reg[0] <= rx_byte;
            for (int j = 1; j < WIN_BYTES - 1; j++) win_reg[j] <= win_reg[j-1];
        end
    end

endmodule

// ===== rtl/at_response_stream_parser_top.sv =====
// Top level of the response stream parser: input handshake and result register.
//
// s_ channel: one received serial byte per transfer in s_tdata[7:0].
// m_ channel: at most one result per input byte. m_tuser carries the event
// kind (0 payload byte, 1 ok, 2 error, 3 send ok, 4 got ip, 5 link down),
// m_tdata[7:0] the payload byte, m_tdata[8] the payload end mark and m_tlast
// the end of a chunk of CHUNK_BYTES bytes (also set on the payload end).
// Line-end events are raised on the newline byte; header lines and ordinary
// text produce no transfer.
// Output: a result is registered and appears on m_ in the cycle after its byte is accepted.
// Throughput: one byte per cycle while no result waits on m_tready low; the parser state updates in the cycle of
// acceptance and a single result register holds the output.
// Stall: while a result waits on m_tready low, s_tready drops; it returns
// in the cycle the result is taken, so a new byte enters as the old leaves.
// Reset (aresetn low, synchronous): line mode, empty line, no payload
// pending, result register empty.
module at_response_stream_parser_top
    import atrsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [8] payload_last, zero above
    output logic [2:0]  m_tuser,   // [2:0] event_kind
    output logic        m_tlast    // chunk_last
);

    evt_t evt;
    logic accept;
    logic               valid_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [7:0]         data_reg;
    logic               chunk_last_reg, payload_last_reg;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    atrsp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .rx_byte (s_tdata),
        .evt     (evt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= accept && evt.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            kind_reg         <= evt.kind;
            data_reg         <= evt.data;
            chunk_last_reg   <= evt.chunk_last;
            payload_last_reg <= evt.payload_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, payload_last_reg, data_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = chunk_last_reg;

endmodule

// ===== tb/at_response_checker.sv =====
// Event predictor and result comparison for the response stream parser bench.
module at_response_checker
    import atrsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_events
);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        data;
        logic              chunk_last;
        logic              payload_last;
    } event_t;

    event_t      event_queue[$];
    logic        in_payload;
    logic [30:0] bytes_left;
    int          chunk_fill;
    int          line_len;
    logic [7:0]  line_buf[LINE_BUFFER_BYTES];

    assign pending_events = event_queue.size();

    function automatic bit line_is(int n, string s);
        if (n != s.len()) return 0;
        for (int i = 0; i < n; i++) if (line_buf[i] != s[i]) return 0;
        return 1;
    endfunction

    function automatic bit line_has(int n, string s);
        bit hit;
        for (int i = 0; i + s.len() <= n; i++) begin
            hit = 1;
            for (int j = 0; j < s.len(); j++) if (line_buf[i+j] != s[j]) hit = 0;
            if (hit) return 1;
        end
        return 0;
    endfunction

    function automatic logic [KIND_W-1:0] line_event();
        int n;
        n = line_len;
        if (n > 0 && line_buf[n-1] == CH_CR) n--;
        for (int i = 0; i < n; i++) if (line_buf[i] == 8'h00) begin n = i; break; end
        if (n == 0) return EV_PAYLOAD;
        if (line_is(n, "OK")) return EV_OK;
        if (line_is(n, "ERROR") || line_is(n, "FAIL")) return EV_ERROR;
        if (line_is(n, "SEND OK")) return EV_SEND_OK;
        if (line_is(n, "SEND FAIL")) return EV_ERROR;
        if (line_has(n, "WIFI GOT IP")) return EV_GOT_IP;
        if (line_has(n, "WIFI DISCONNECT")) return EV_LINK_DOWN;
        if (line_is(n, "CLOSED")) return EV_LINK_DOWN;
        return EV_PAYLOAD;
    endfunction

    function automatic longint header_length();
        int i;
        longint v;
        bit neg;
        i = 5; v = 0; neg = 0;
        while (i < line_len && (line_buf[i] == CH_SPACE ||
               (line_buf[i] >= CH_TAB && line_buf[i] <= CH_CR))) i++;
        if (i < line_len && (line_buf[i] == CH_PLUS || line_buf[i] == CH_MINUS)) begin
            neg = (line_buf[i] == CH_MINUS);
            i++;
        end
        while (i < line_len && line_buf[i] >= CH_ZERO && line_buf[i] <= CH_NINE) begin
            v = v * 10 + (line_buf[i] - CH_ZERO);
            if (v > LEN_LIMIT) v = LEN_LIMIT;
            i++;
        end
        return neg ? 0 : v;
    endfunction

    task automatic predict_byte(logic [7:0] b);
        event_t e;
        logic [KIND_W-1:0] k;
        longint n;
        if (in_payload) begin
            bytes_left = bytes_left - 1;
            chunk_fill++;
            e.kind = EV_PAYLOAD;
            e.data = b;
            e.payload_last = (bytes_left == 0);
            e.chunk_last = e.payload_last || chunk_fill >= CHUNK_BYTES;
            if (e.chunk_last) chunk_fill = 0;
            if (e.payload_last) in_payload = 0;
            event_queue.push_back(e);
        end else if (b == CH_LF) begin
            k = line_event();
            line_len = 0;
            if (k != EV_PAYLOAD) begin
                e = '{kind: k, data: 8'h00, chunk_last: 1'b0, payload_last: 1'b0};
                event_queue.push_back(e);
            end
        end else if (line_len >= LINE_BUFFER_BYTES - 1) begin
            line_len = 0;
        end else begin
            line_buf[line_len] = b;
            line_len++;
            if (b == CH_COLON && line_len >= 6 && line_buf[0] == "+" &&
                line_buf[1] == "I" && line_buf[2] == "P" && line_buf[3] == "D" &&
                line_buf[4] == ",") begin
                n = header_length();
                bytes_left = n[30:0];
                chunk_fill = 0;
                in_payload = (n > 0);
                line_len = 0;
            end
        end
    endtask

    task automatic report_mismatch(string what);
        $display("%0t: mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        event_t want;
        if (!aresetn) begin
            in_payload <= 0;
            bytes_left <= '0;
            chunk_fill <= 0;
            line_len   <= 0;
            fail_count <= 0;
            event_queue.delete();
            for (int i = 0; i < LINE_BUFFER_BYTES; i++) line_buf[i] = 8'h00;
        end else begin
            if (m_tvalid && m_tready) begin
                if (event_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected event kind %0d", m_tuser));
                end else begin
                    want = event_queue.pop_front();
                    if (m_tuser != want.kind || m_tdata[7:0] != want.data ||
                        m_tdata[8] != want.payload_last || m_tlast != want.chunk_last ||
                        m_tdata[15:9] != 7'd0)
                        report_mismatch($sformatf(
                            "got kind %0d byte %h plast %b clast %b, want %0d %h %b %b",
                            m_tuser, m_tdata[7:0], m_tdata[8], m_tlast,
                            want.kind, want.data, want.payload_last, want.chunk_last));
                end
            end
            if (s_tvalid && s_tready) predict_byte(s_tdata);
        end
    end

endmodule

// ===== tb/tb_at_response_stream_parser_top.sv =====
// Stimulus, clocking and verdict for the response stream parser bench.
module tb_at_response_stream_parser_top;
    import atrsp_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending_events;
    int          send_idle_pct = 28;
    int          recv_idle_pct = 70;
    int          hold_cycles = 0;

    always #5 aclk = ~aclk;

    at_response_stream_parser_top i_dut (.*);

    at_response_checker i_chk (.*);

    // receiver: random idling, or a long counted hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 0;
        else if (hold_cycles > 0) begin
            m_tready <= 0;
            hold_cycles <= hold_cycles - 1;
        end else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // keep tvalid high between back-to-back transfers; drop it only when idling
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_payload_frame(int len);
        send_text($sformatf("+IPD,%0d:", len));
        repeat (len) send_byte(8'($urandom_range(255)));
    endtask

    task automatic drain_events();
        s_tvalid <= 0;
        while (pending_events != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic string random_line();
        string pick[12] = '{"OK", "ERROR", "FAIL", "SEND OK", "SEND FAIL", "CLOSED",
            "WIFI GOT IP", "xxWIFI DISCONNECTyy", "OK\r", "OKK", "CLOSED\r", "AT"};
        string s;
        s = pick[$urandom_range(11)];
        if ($urandom_range(3) == 0) s = {s, "\r"};
        return s;
    endfunction

    task automatic random_phase(int count);
        int done;
        int r;
        string s;
        done = 0;
        while (done < count) begin
            r = $urandom_range(9);
            if (r < 4) begin
                s = {random_line(), "\n"};
                send_text(s);
                done += s.len();
            end else if (r < 7) begin
                r = $urandom_range(1, 12);
                if ($urandom_range(15) == 0) r = $urandom_range(129, 260);
                send_payload_frame(r);
                done += r + 8;
            end else if (r < 8) begin
                s = $sformatf("+IPD,%s%0d:", ($urandom_range(1) ? " -" : "\t+"),
                              $urandom_range(0, 3));
                send_text(s);
                if (s[6] == "+" && s[7] != "0") repeat (s[7] - "0") send_byte(8'($urandom));
                done += s.len();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_byte(8'($urandom_range(255)));
                    done++;
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed lines and special cases
        send_text("OK\r\nERROR\nFAIL\nSEND OK\r\nSEND FAIL\nCLOSED\n");
        send_text("ab WIFI GOT IP\nWIFI DISCONNECT\n\r\n\n");
        send_text("OK");
        send_byte(8'h00);
        send_text("zz\nO\377\n");
        send_payload_frame(1);
        send_payload_frame(3);
        send_text("+IPD,  -5:\n+IPD,x:\n+IPD,0:\n");
        drain_events();
        // overlong line, then a normal one, then a long payload
        repeat (130) send_byte(8'h41);
        send_text("\nOK\n");
        send_payload_frame(300);
        drain_events();
        // pressure: long hold-off while bytes keep coming
        hold_cycles = 200;
        send_payload_frame(40);
        drain_events();
        random_phase(200);
        drain_events();
        send_idle_pct = 70; recv_idle_pct = 28;
        random_phase(200);
        drain_events();
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(200);
        drain_events();
        // saturating length header: payload stays pending to the end
        send_text("+IPD,99999999999:");
        for (int i = 0; i < 2; i++) send_byte(8'hFF);
        drain_events();
        repeat (30) @(posedge aclk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
